[design/cmdf_pkg.sv]
// Package for the complex mixer and decimating FIR block.
// Holds shared constants, the sequencer state type and the cell control struct.
// No dependencies.
package cmdf_pkg;

  localparam int DEF_MAX_TAPS      = 64;
  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_LUT_ADDR_BITS = 10;

  localparam int COEFF_BITS  = 18;
  localparam int CINDEX_BITS = 6;
  localparam int CFG_W       = 32;
  localparam int CFG_ADDR_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECIMATION = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT  = 2'd2;

  // Action codes carried in tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Quarter-wave sine polynomial constants, Q16.
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [15:0] POLY_B = 16'd42047;
  localparam logic [12:0] POLY_C = 13'd4639;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_T1,
    ST_T2,
    ST_SIN,
    ST_MIX1,
    ST_MIX2,
    ST_ROT,
    ST_DRAIN,
    ST_ROUND
  } cmdf_state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

endpackage

[design/cmdf_cell.sv]
// One cell of the delay-line ring: a complex sample and one coefficient.
// Depends on cmdf_pkg.
module cmdf_cell import cmdf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cell_ctl_t                     ctl,
  input  logic                          load_en,
  input  logic signed [COEFF_BITS-1:0]  load_val,
  input  logic signed [SAMPLE_BITS-1:0] shift_in_i,
  input  logic signed [SAMPLE_BITS-1:0] shift_in_q,
  input  logic signed [SAMPLE_BITS-1:0] rot_in_i,
  input  logic signed [SAMPLE_BITS-1:0] rot_in_q,
  input  logic signed [COEFF_BITS-1:0]  rot_in_c,
  output logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] d_q,
  output logic signed [COEFF_BITS-1:0]  c
);

  logic signed [SAMPLE_BITS-1:0] d_i_r, d_i_nxt, d_q_r, d_q_nxt;
  logic signed [COEFF_BITS-1:0]  c_r, c_nxt;

  // During a rotation sample and coefficient travel together, so after a full
  // turn every cell holds its own contents again.
  always_comb begin
    d_i_nxt = d_i_r;
    d_q_nxt = d_q_r;
    c_nxt   = c_r;
    if (ctl.rotate) begin
      d_i_nxt = rot_in_i;
      d_q_nxt = rot_in_q;
      c_nxt   = rot_in_c;
    end else if (ctl.shift) begin
      d_i_nxt = shift_in_i;
      d_q_nxt = shift_in_q;
    end else if (load_en) begin
      c_nxt = load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_i_r <= '0;
      d_q_r <= '0;
      c_r   <= '0;
    end else begin
      d_i_r <= d_i_nxt;
      d_q_r <= d_q_nxt;
      c_r   <= c_nxt;
    end
  end

  assign d_i = d_i_r;
  assign d_q = d_q_r;
  assign c   = c_r;

endmodule

[design/complex_mix_decimate_fir_top.sv]
// A sample word passes the oscillator states (SQ, T1, T2, SIN) and the mixer
// (MIX1, MIX2); on a decimation hit the ring then rotates past the one shared
// MAC, and DRAIN and ROUND give the output word, ROUND waiting on a stall. A
// coefficient load leaves the block idle; a sample blocks input until done.
// Reset (synchronous, rst_n low) clears phase step, phase, counters, delay line
// and coefficients (decimation 1, 64 taps); ready the first cycle after reset.
module complex_mix_decimate_fir_top import cmdf_pkg::*; #(
  parameter int MAX_TAPS      = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int LUT_ADDR_BITS = DEF_LUT_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: sample_i, sample_q, coeff_index, coeff_value, zero fill.
  input  logic [((2*SAMPLE_BITS+CINDEX_BITS+COEFF_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: action (0 = sample, 1 = coefficient load).
  input  logic                  in_tuser,
  // Output stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0: out_i, out_q, zero fill.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int IW     = $clog2(MAX_TAPS);
  localparam int TCW    = (IW + 1 > 7) ? IW + 1 : 7;
  localparam int OUT_W  = ((2*SB+7)/8)*8;
  localparam int L      = LUT_ADDR_BITS;
  localparam int MIX_W  = SB + 17;
  localparam int PROD_W = SB + COEFF_BITS;
  localparam int ACC_W  = PROD_W + IW + 1;

  localparam logic signed [MIX_W-1:0] MIX_MAX = MIX_W'((1 << (SB-1)) - 1);
  localparam logic signed [MIX_W-1:0] MIX_MIN = -MIX_W'(1 << (SB-1));
  localparam logic signed [MIX_W-1:0] MIX_RND = MIX_W'(1 << 14);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((1 << (SB-1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(1 << (SB-1));
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1 << 16);
  localparam logic [L-2:0]            QUARTER = (L-1)'(1 << (L-2));

  // Input fields.
  logic signed [SB-1:0]         in_si, in_sq;
  logic [CINDEX_BITS-1:0]       in_ci;
  logic signed [COEFF_BITS-1:0] in_cv;
  assign in_si = in_tdata[SB-1:0];
  assign in_sq = in_tdata[2*SB-1:SB];
  assign in_ci = in_tdata[2*SB+CINDEX_BITS-1:2*SB];
  assign in_cv = in_tdata[2*SB+CINDEX_BITS+COEFF_BITS-1:2*SB+CINDEX_BITS];

  cmdf_state_t state_r, state_nxt;
  cell_ctl_t   ctl;
  logic        acc_in, take_sample, take_load, out_free, fire;

  logic [31:0] phase_step_r, phase_acc_r;
  logic [6:0]  decim_r, taps_r, dcount_r, dcount_inc;
  logic [IW-1:0] rot_r;

  logic signed [SB-1:0] xi_r, xq_r;
  logic [1:0]  sq_r, cq_r;
  logic [16:0] su_r, cu_r, su2_r, cu2_r, st2_r, ct2_r;
  logic [15:0] st1_r, ct1_r;
  logic signed [15:0] sv_r, cv_r;
  logic signed [SB+15:0] p_ic_r, p_qs_r, p_qc_r, p_is_r;
  logic signed [PROD_W-1:0] prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;
  logic signed [SB-1:0]     oi_r, oq_r;
  logic                     ovalid_r;

  // Oscillator addresses for sine and cosine.
  logic [L-1:0]   sidx, cidx;
  logic [L-2:0]   sw, cw;
  assign sidx = phase_acc_r[31 -: L];
  assign cidx = sidx + L'(1 << (L-2));
  assign sw   = sidx[L-2] ? QUARTER - {1'b0, sidx[L-3:0]} : {1'b0, sidx[L-3:0]};
  assign cw   = cidx[L-2] ? QUARTER - {1'b0, cidx[L-3:0]} : {1'b0, cidx[L-3:0]};

  // Polynomial steps.
  logic [33:0] s_sq, c_sq, s_t2p, c_t2p;
  logic [29:0] s_t1p, c_t1p;
  logic [32:0] s_tp, c_tp;
  logic [18:0] s_r, c_r;
  logic [15:0] s_mag, c_mag;
  assign s_sq  = su_r * su_r;
  assign c_sq  = cu_r * cu_r;
  assign s_t1p = POLY_C * su2_r;
  assign c_t1p = POLY_C * cu2_r;
  assign s_tp  = st1_r * su2_r;
  assign c_tp  = ct1_r * cu2_r;
  assign s_t2p = st2_r * su_r;
  assign c_t2p = ct2_r * cu_r;
  assign s_r   = (19'(s_t2p[33:16]) + 19'd1) >> 1;
  assign c_r   = (19'(c_t2p[33:16]) + 19'd1) >> 1;
  assign s_mag = (s_r > 19'd32767) ? 16'd32767 : s_r[15:0];
  assign c_mag = (c_r > 19'd32767) ? 16'd32767 : c_r[15:0];

  // Mixer rounding and saturation.
  logic signed [MIX_W-1:0] mix_i, mix_q, mix_ir, mix_qr;
  logic signed [SB-1:0]    mix_is, mix_qs;
  assign mix_i  = MIX_W'(p_ic_r) + MIX_W'(p_qs_r) + MIX_RND;
  assign mix_q  = MIX_W'(p_qc_r) - MIX_W'(p_is_r) + MIX_RND;
  assign mix_ir = mix_i >>> 15;
  assign mix_qr = mix_q >>> 15;
  assign mix_is = (mix_ir > MIX_MAX) ? SB'(MIX_MAX) :
                  (mix_ir < MIX_MIN) ? SB'(MIX_MIN) : SB'(mix_ir);
  assign mix_qs = (mix_qr > MIX_MAX) ? SB'(MIX_MAX) :
                  (mix_qr < MIX_MIN) ? SB'(MIX_MIN) : SB'(mix_qr);

  // Decimation: an output word when the incremented count reaches decimation.
  assign dcount_inc = dcount_r + 7'd1;
  assign fire       = !(dcount_inc < decim_r);

  // Effective tap count, clamped to 1..MAX_TAPS.
  logic [TCW-1:0] taps_eff;
  always_comb begin
    priority if (taps_r == 7'd0)                   taps_eff = TCW'(1);
    else if (TCW'(taps_r) > TCW'(MAX_TAPS))        taps_eff = TCW'(MAX_TAPS);
    else                                           taps_eff = TCW'(taps_r);
  end

  // Filter rounding and saturation.
  logic signed [ACC_W-1:0] fir_i, fir_q;
  assign fir_i = (acc_i_r + ACC_RND) >>> 17;
  assign fir_q = (acc_q_r + ACC_RND) >>> 17;

  assign out_free    = !ovalid_r || out_tready;
  assign acc_in      = in_tvalid && in_tready;
  assign take_sample = acc_in && (in_tuser == ACT_SAMPLE);
  assign take_load   = acc_in && (in_tuser == ACT_LOAD);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take_sample) state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_T1;
      ST_T1:    state_nxt = ST_T2;
      ST_T2:    state_nxt = ST_SIN;
      ST_SIN:   state_nxt = ST_MIX1;
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = fire ? ST_ROT : ST_IDLE;
      ST_ROT:   if (rot_r == IW'(MAX_TAPS-1)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready  = 1'b0;
    ctl.shift  = 1'b0;
    ctl.rotate = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_MIX2: ctl.shift  = 1'b1;
      ST_ROT:  ctl.rotate = 1'b1;
      default: ;
    endcase
  end

  // The ring of cells. Cell 0 holds the newest sample; the mixed sample enters
  // it straight from the rounding logic in the shift cycle.
  logic signed [SB-1:0]         cell_i [MAX_TAPS];
  logic signed [SB-1:0]         cell_q [MAX_TAPS];
  logic signed [COEFF_BITS-1:0] cell_c [MAX_TAPS];

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_TAPS;
    logic signed [SB-1:0] sh_i, sh_q;
    if (k == 0) begin : g_head
      assign sh_i = mix_is;
      assign sh_q = mix_qs;
    end else begin : g_body
      assign sh_i = cell_i[k-1];
      assign sh_q = cell_q[k-1];
    end
    cmdf_cell #(.SAMPLE_BITS(SB)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load_en    (take_load && (32'(in_ci) == k)),
      .load_val   (in_cv),
      .shift_in_i (sh_i),
      .shift_in_q (sh_q),
      .rot_in_i   (cell_i[NXT]),
      .rot_in_q   (cell_q[NXT]),
      .rot_in_c   (cell_c[NXT]),
      .d_i        (cell_i[k]),
      .d_q        (cell_q[k]),
      .c          (cell_c[k])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_step_r <= '0;
      decim_r      <= 7'd1;
      taps_r       <= 7'd64;
      phase_acc_r  <= '0;
      dcount_r     <= '0;
      rot_r        <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PHASE_STEP: phase_step_r <= cfg_wdata;
          REG_DECIMATION: decim_r      <= cfg_wdata[6:0];
          REG_TAP_COUNT:  taps_r       <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (state_r == ST_MIX2) begin
        phase_acc_r <= phase_acc_r + phase_step_r;
        dcount_r    <= fire ? 7'd0 : dcount_inc;
        rot_r       <= '0;
      end
      if (state_r == ST_ROT) rot_r <= rot_r + IW'(1);
      if (state_r == ST_ROUND && out_free) ovalid_r <= 1'b1;
      else if (out_tready)                 ovalid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      xi_r <= in_si;
      xq_r <= in_sq;
      sq_r <= sidx[L-1:L-2];
      cq_r <= cidx[L-1:L-2];
      su_r <= 17'(sw) << (18 - L);
      cu_r <= 17'(cw) << (18 - L);
    end
    unique case (state_r)
      ST_SQ: begin
        su2_r <= s_sq[32:16];
        cu2_r <= c_sq[32:16];
      end
      ST_T1: begin
        st1_r <= POLY_B - 16'(s_t1p[29:16]);
        ct1_r <= POLY_B - 16'(c_t1p[29:16]);
      end
      ST_T2: begin
        st2_r <= POLY_A - s_tp[32:16];
        ct2_r <= POLY_A - c_tp[32:16];
      end
      ST_SIN: begin
        sv_r <= sq_r[1] ? -$signed(s_mag) : $signed(s_mag);
        cv_r <= cq_r[1] ? -$signed(c_mag) : $signed(c_mag);
      end
      ST_MIX1: begin
        p_ic_r <= xi_r * cv_r;
        p_qs_r <= xq_r * sv_r;
        p_qc_r <= xq_r * cv_r;
        p_is_r <= xi_r * sv_r;
      end
      ST_MIX2: begin
        acc_i_r  <= '0;
        acc_q_r  <= '0;
        prod_i_r <= '0;
        prod_q_r <= '0;
      end
      ST_ROT: begin
        // Cell 0 holds tap rot_r in this cycle.
        if (TCW'(rot_r) < taps_eff) begin
          prod_i_r <= cell_c[0] * cell_i[0];
          prod_q_r <= cell_c[0] * cell_q[0];
        end else begin
          prod_i_r <= '0;
          prod_q_r <= '0;
        end
        acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
        acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
      end
      ST_DRAIN: begin
        acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
        acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
      end
      ST_ROUND: begin
        if (out_free) begin
          oi_r <= (fir_i > ACC_MAX) ? SB'(ACC_MAX) :
                  (fir_i < ACC_MIN) ? SB'(ACC_MIN) : SB'(fir_i);
          oq_r <= (fir_q > ACC_MAX) ? SB'(ACC_MAX) :
                  (fir_q < ACC_MIN) ? SB'(ACC_MIN) : SB'(fir_q);
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_W'({oq_r, oi_r});

endmodule

[design/cmdf_checker.sv]
// Port-level checks for the complex mixer and decimating FIR block.
// Depends on cmdf_pkg; bound to complex_mix_decimate_fir_top.
module cmdf_port_props import cmdf_pkg::*; #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // No output word in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // A coefficient load never produces an output word.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_LOAD |=> !$rose(out_tvalid))
    else $error("coefficient load produced output");

  // An accepted sample word deasserts in_tready while it occupies the datapath.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_SAMPLE |=> !in_tready)
    else $error("input accepted while a sample is in flight");

endmodule

bind complex_mix_decimate_fir_top cmdf_port_props #(.OUT_W($bits(out_tdata))) u_cmdf_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/cmdf_checker.sv]
// Checker for the complex mixer and decimating FIR block: watches both streams,
// predicts each filter output and compares it field by field.
// Depends on cmdf_pkg and on the input/output word layout of the top level.
`timescale 1ns / 1ps
module cmdf_checker import cmdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int NTAPS = 64;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] i;
  } iq_t;

  logic [31:0] nco_step;
  logic [6:0]  decim_ratio;
  logic [6:0]  taps_used;
  logic [31:0] nco_phase;
  logic signed [15:0] line_i [NTAPS];
  logic signed [15:0] line_q [NTAPS];
  logic signed [17:0] coeffs [NTAPS];
  logic [5:0]  wr_pos;
  logic [6:0]  decim_cnt;
  iq_t         expected_out [$];

  // Quarter-wave polynomial sine, Q15, for a 10-bit table index.
  function automatic longint sine_q15(input logic [9:0] idx);
    logic [1:0] quad;
    longint w, u, u2, t, s, r;
    quad = idx[9:8];
    w = idx[7:0];
    if (quad[0]) w = 256 - w;
    u = w << 8;
    u2 = (u * u) >>> 16;
    t = (4639 * u2) >>> 16;
    t = 42047 - t;
    t = (t * u2) >>> 16;
    t = 102944 - t;
    s = (t * u) >>> 16;
    r = (s + 1) >>> 1;
    if (r > 32767) r = 32767;
    return quad[1] ? -r : r;
  endfunction

  // Arithmetic shift floors, which is round half up after the bias.
  function automatic longint round_sat(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic take_word(input logic act, input logic [55:0] d);
    logic [9:0] idx;
    longint xi, xq, sp, cp, acc_i, acc_q;
    int ntaps, pos;
    iq_t res;
    if (act == ACT_LOAD) begin
      coeffs[d[37:32]] = d[55:38];
      return;
    end
    xi = $signed(d[15:0]);
    xq = $signed(d[31:16]);
    idx = nco_phase[31:22];
    sp = sine_q15(idx);
    cp = sine_q15(idx + 10'd256);
    line_i[wr_pos] = round_sat(xi * cp + xq * sp, 15);
    line_q[wr_pos] = round_sat(xq * cp - xi * sp, 15);
    nco_phase += nco_step;
    wr_pos++;
    decim_cnt++;
    if (decim_cnt < decim_ratio) return;
    decim_cnt = 0;
    ntaps = taps_used == 0 ? 1 : (taps_used > NTAPS ? NTAPS : taps_used);
    acc_i = 0;
    acc_q = 0;
    for (int k = 0; k < ntaps; k++) begin
      pos = (wr_pos + 2 * NTAPS - 1 - k) % NTAPS;
      acc_i += longint'(coeffs[k]) * line_i[pos];
      acc_q += longint'(coeffs[k]) * line_q[pos];
    end
    res.i = round_sat(acc_i, 17);
    res.q = round_sat(acc_q, 17);
    expected_out.push_back(res);
  endtask

  always @(posedge clk) begin
    iq_t got, want;
    if (!rst_n) begin
      nco_step = 0; decim_ratio = 1; taps_used = 64; nco_phase = 0;
      wr_pos = 0; decim_cnt = 0; fail_count = 0;
      for (int k = 0; k < NTAPS; k++) begin
        line_i[k] = 0; line_q[k] = 0; coeffs[k] = 0;
      end
      expected_out.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_STEP: nco_step = cfg_wdata;
          REG_DECIMATION: decim_ratio = cfg_wdata[6:0];
          REG_TAP_COUNT:  taps_used = cfg_wdata[6:0];
          default: ;
        endcase
      end
      // Outputs are checked before the input word of the same edge is taken,
      // since a result can never stem from a word accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_out.size() == 0) begin
          $error("unexpected output word i=%0d q=%0d", got.i, got.q);
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          if (got.i !== want.i) begin
            $error("out_i expected %0d actual %0d", want.i, got.i);
            fail_count++;
          end
          if (got.q !== want.q) begin
            $error("out_q expected %0d actual %0d", want.q, got.q);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) take_word(in_tuser, in_tdata);
    end
    pending = expected_out.size();
  end
endmodule

[test/tb_top.sv]
// Testbench top for the complex mixer and decimating FIR block: drives
// configuration and input words, stalls the output side at random and gives the verdict.
// Depends on cmdf_pkg, the block itself and cmdf_checker.
`timescale 1ns / 1ps
module tb_top;
  import cmdf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = ACT_SAMPLE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;

  // A word that drains an output walks the whole ring, and the longest stall on
  // either side is short beside WATCHDOG_LIMIT, so the limit is ample.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_mix_decimate_fir_top uut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  cmdf_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending
  );

  // Gap length: mostly zero or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 35);
  endfunction

  // The output side stalls at random, in phases with and without back-pressure.
  bit sink_steady = 1'b0;
  always @(negedge clk) begin
    int g;
    if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
    if (sink_steady || !rst_n) begin
      out_tready <= rst_n;
    end else begin
      g = gap_len();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // Watchdog on accepted traffic of any kind.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One register write, with the enable dropped again before the task returns, so
  // that it is never lowered and raised again at the same edge.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Presents one word and holds it until the block takes it. A random gap, if
  // allowed, comes before it, so valid is never dropped and raised at one edge.
  task automatic send_word(input logic act, input logic signed [15:0] si,
                           input logic signed [15:0] sq, input logic [5:0] ci,
                           input logic signed [17:0] cv, input bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {cv, ci, sq, si};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
    send_word(ACT_SAMPLE, si, sq, 6'($urandom), 18'($urandom), 1'b1);
  endtask

  task automatic send_coeff(input logic [5:0] ci, input logic signed [17:0] cv);
    send_word(ACT_LOAD, 16'($urandom), 16'($urandom), ci, cv, 1'b1);
  endtask

  // Waits until every expected output has come out, then lets the longest
  // internal pipeline run dry, so a new register setting cannot hit work
  // that produces no output.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int sample_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < sample_pct) begin
        case ($urandom_range(0, 4))
          0: send_sample(16'sh7fff, 16'sh8000);
          1: send_sample(16'sh8000, 16'sh7fff);
          default: send_sample(16'($urandom), 16'($urandom));
        endcase
      end else begin
        send_coeff(6'($urandom), $urandom_range(0, 3) == 0 ?
                   ($urandom_range(0, 1) ? 18'sh1ffff : 18'sh20000) : 18'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under reset settings: all 64 taps, no decimation.
    // Unloaded coefficients read as zero, so the first output is zero.
    send_sample(16'sh7fff, 16'sh7fff);
    send_coeff(6'd0, 18'sh1ffff);
    send_coeff(6'd63, 18'sh20000);
    send_coeff(6'd1, 18'sh1ffff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'shffff, 16'sh0001);
    wait_quiet();
    // Tap count zero acts as one, decimation zero as one; extreme phase step.
    write_reg(REG_TAP_COUNT, 32'd0);
    write_reg(REG_DECIMATION, 32'd0);
    write_reg(REG_PHASE_STEP, 32'h8000_0000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh4000, 16'shc000);
    wait_quiet();
    // Above the maximum: 127 taps saturate to 64; decimation 5.
    write_reg(REG_TAP_COUNT, 32'd127);
    write_reg(REG_DECIMATION, 32'd5);
    write_reg(REG_PHASE_STEP, 32'h7fff_ffff);
    for (int k = 0; k < 3; k++) send_sample(16'($urandom), 16'($urandom));
    wait_quiet();
    // Decimation lowered below the running count: next sample fires.
    write_reg(REG_DECIMATION, 32'd2);
    send_sample(16'sh1234, 16'sh8765);
    wait_quiet();

    // Random phases through several settings, extremes among them.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_PHASE_STEP, ph == 0 ? 32'h0 : (ph == 1 ? 32'h8000_0000 : $urandom));
      write_reg(REG_DECIMATION, ph < 3 ? 32'd1 : (ph == 3 ? 32'd64 :
                (ph == 11 ? 32'($urandom_range(0, 127)) : 32'($urandom_range(1, 8)))));
      write_reg(REG_TAP_COUNT, ph == 2 ? 32'd1 : (ph == 4 ? 32'd64 :
                32'($urandom_range(0, 127))));
      random_phase(ph == 3 ? 260 : 100, 85);
      wait_quiet();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

[filelist.f]
design/cmdf_pkg.sv
design/cmdf_cell.sv
design/complex_mix_decimate_fir_top.sv
design/cmdf_checker.sv
test/cmdf_checker.sv
test/tb_top.sv
